### hw/rtl/leader_cluster_running_mean_assert.svh
// Assertion macros shared by the clustering block.
`ifndef LEADER_CLUSTER_RUNNING_MEAN_ASSERT_SVH
`define LEADER_CLUSTER_RUNNING_MEAN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCRM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcrm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LCRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcrm: next-cycle check failed");

`endif

### hw/rtl/lcrm_pkg.sv
`default_nettype none

package lcrm_pkg;

   localparam int COORD_BITS  = 16;
   localparam int FRAC_BITS   = 8;
   localparam int MEAN_BITS   = COORD_BITS + FRAC_BITS;
   localparam int COUNT_BITS  = 16;
   localparam int THRESH_BITS = 16;
   localparam int ENTRY_BITS  = MEAN_BITS + COUNT_BITS;
   localparam int PROD_BITS   = MEAN_BITS + COUNT_BITS;
   localparam int SUM_BITS    = PROD_BITS + 1;
   localparam int REM_BITS    = SUM_BITS - MEAN_BITS;
   localparam int DIVR_BITS   = COUNT_BITS + 1;
   localparam int DCNT_BITS   = $clog2(MEAN_BITS);

   localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = '1;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(30);

   typedef struct packed {
      logic load_point;
      logic ram_read;
      logic scan_next;
      logic capture;
      logic div_init;
      logic div_step;
      logic write_hit;
      logic write_miss;
   } lcrm_cmd_type;

   typedef struct packed {
      logic in_use_zero;
      logic scan_last;
      logic hit;
      logic div_last;
      logic out_free;
   } lcrm_status_type;

endpackage

`default_nettype wire

### hw/rtl/leader_cluster_running_mean.sv
`default_nettype none

// One-dimensional leader clustering with running means. Each beat on the req_
// channel carries one point; the block scans the open clusters in creation
// order, reading each table entry in a read state and comparing it in a compare
// state, through a table with one write port and one registered read port, and
// the first cluster whose mean lies strictly closer than the threshold takes the
// point. Its new mean comes from a restoring divider that retires one quotient
// bit per cycle. A point that no open cluster takes opens a new cluster, or is
// dropped when the table is full; one item is worked on at a time, and the
// next is accepted while the previous result still waits in the rsp_ output
// register. The cluster table needs no clearing after reset, and the threshold
// register may be written only while the block is idle.
module leader_cluster_running_mean #(
   parameter int MAX_CLUSTERS = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [lcrm_pkg::COORD_BITS-1:0]         req_point_value,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic      [$clog2(MAX_CLUSTERS)-1:0]         rsp_cluster_index,
   output logic                                         rsp_opened_new,
   output logic                                         rsp_table_full_drop,
   output logic      [lcrm_pkg::MEAN_BITS-1:0]          rsp_cluster_mean,
   output logic      [lcrm_pkg::COUNT_BITS-1:0]         rsp_cluster_size,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [lcrm_pkg::THRESH_BITS-1:0]        csr_match_threshold
);

   import lcrm_pkg::*;

   lcrm_cmd_type    cmd;
   lcrm_status_type status;

   assign csr_ready = 1'b1;

   lcrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lcrm_dp #(
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_point_value     (req_point_value),
      .csr_valid           (csr_valid),
      .csr_match_threshold (csr_match_threshold),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cluster_index   (rsp_cluster_index),
      .rsp_opened_new      (rsp_opened_new),
      .rsp_table_full_drop (rsp_table_full_drop),
      .rsp_cluster_mean    (rsp_cluster_mean),
      .rsp_cluster_size    (rsp_cluster_size)
   );

endmodule

`default_nettype wire

### hw/rtl/lcrm_ram.sv
`default_nettype none

module lcrm_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hw/rtl/lcrm_ctrl.sv
`default_nettype none

`include "leader_cluster_running_mean_assert.svh"

module lcrm_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire lcrm_pkg::lcrm_status_type status,
   output lcrm_pkg::lcrm_cmd_type        cmd
);

   import lcrm_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_READ   = 7'b0000010,
      S_CMP    = 7'b0000100,
      S_DIVI   = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_FINISH = 7'b0100000,
      S_MISS   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_point = 1'b1;
               state_in       = status.in_use_zero ? S_MISS : S_READ;
            end
         end
         S_READ: begin
            cmd.ram_read = 1'b1;
            state_in     = S_CMP;
         end
         S_CMP: begin
            priority if (status.hit) begin
               cmd.capture = 1'b1;
               state_in    = S_DIVI;
            end else if (status.scan_last) begin
               state_in = S_MISS;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_READ;
            end
         end
         S_DIVI: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.write_hit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_MISS: begin
            if (status.out_free) begin
               cmd.write_miss = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `LCRM_ASSERT_NEXT(a_accept_starts_work, clock, reset,
      req_valid && !req_stall, state_ff == S_READ || state_ff == S_MISS)
   `LCRM_ASSERT_NEXT(a_divide_then_finish, clock, reset,
      state_ff == S_DIV && status.div_last, state_ff == S_FINISH)

endmodule

`default_nettype wire

### hw/rtl/lcrm_dp.sv
`default_nettype none

`include "leader_cluster_running_mean_assert.svh"

module lcrm_dp #(
   parameter int MAX_CLUSTERS = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire lcrm_pkg::lcrm_cmd_type                  cmd,
   output lcrm_pkg::lcrm_status_type                    status,
   input  wire logic [lcrm_pkg::COORD_BITS-1:0]         req_point_value,
   input  wire logic                                    csr_valid,
   input  wire logic [lcrm_pkg::THRESH_BITS-1:0]        csr_match_threshold,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic      [$clog2(MAX_CLUSTERS)-1:0]         rsp_cluster_index,
   output logic                                         rsp_opened_new,
   output logic                                         rsp_table_full_drop,
   output logic      [lcrm_pkg::MEAN_BITS-1:0]          rsp_cluster_mean,
   output logic      [lcrm_pkg::COUNT_BITS-1:0]         rsp_cluster_size
);

   import lcrm_pkg::*;

   localparam int IDX_W = $clog2(MAX_CLUSTERS);
   localparam int USE_W = $clog2(MAX_CLUSTERS + 1);

   logic [THRESH_BITS-1:0] thr_ff;
   logic [USE_W-1:0]       in_use_ff;
   logic [USE_W-1:0]       in_use_in;
   logic [IDX_W-1:0]       scan_idx_ff;
   logic [IDX_W-1:0]       scan_idx_in;
   logic [MEAN_BITS-1:0]   point_ff;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [COUNT_BITS-1:0]  cnt_ff;
   logic [COUNT_BITS-1:0]  newcnt_ff;
   logic [DIVR_BITS-1:0]   divisor_ff;
   logic [REM_BITS-1:0]    rem_ff;
   logic [MEAN_BITS-1:0]   quo_ff;
   logic [DCNT_BITS-1:0]   div_cnt_ff;
   logic                   rsp_valid_ff;
   logic [IDX_W-1:0]       out_idx_ff;
   logic                   out_opened_ff;
   logic                   out_drop_ff;
   logic [MEAN_BITS-1:0]   out_mean_ff;
   logic [COUNT_BITS-1:0]  out_size_ff;

   logic [ENTRY_BITS-1:0]  rdata;
   logic [ENTRY_BITS-1:0]  wdata;
   logic [IDX_W-1:0]       waddr;
   logic                   we;
   logic                   full;
   logic [MEAN_BITS-1:0]   mean_rd;
   logic [COUNT_BITS-1:0]  cnt_rd;
   logic [MEAN_BITS-1:0]   gap;
   logic [MEAN_BITS-1:0]   thr_scaled;
   logic [SUM_BITS-1:0]    sum;
   logic [REM_BITS:0]      trial;
   logic [REM_BITS:0]      diff;
   logic                   qbit;
   logic                   out_free;

   assign mean_rd    = rdata[ENTRY_BITS-1 -: MEAN_BITS];
   assign cnt_rd     = rdata[COUNT_BITS-1:0];
   assign gap        = (mean_rd >= point_ff) ? (mean_rd - point_ff) : (point_ff - mean_rd);
   assign thr_scaled = MEAN_BITS'(thr_ff) << FRAC_BITS;
   assign full       = (in_use_ff == USE_W'(MAX_CLUSTERS));
   assign sum        = SUM_BITS'(prod_ff) + SUM_BITS'(point_ff);
   assign trial      = {rem_ff, quo_ff[MEAN_BITS-1]};
   assign diff       = trial - (REM_BITS+1)'(divisor_ff);
   assign qbit       = (trial >= (REM_BITS+1)'(divisor_ff));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign we    = cmd.write_hit || (cmd.write_miss && !full);
   assign waddr = cmd.write_hit ? scan_idx_ff : in_use_ff[IDX_W-1:0];
   assign wdata = cmd.write_hit ? {quo_ff, newcnt_ff} : {point_ff, COUNT_BITS'(1)};

   lcrm_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_CLUSTERS)
   ) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (cmd.ram_read),
      .raddr (scan_idx_ff),
      .rdata (rdata)
   );

   always_comb begin
      status.in_use_zero = (in_use_ff == '0);
      status.scan_last   = ((USE_W'(scan_idx_ff) + USE_W'(1)) == in_use_ff);
      status.hit         = (gap < thr_scaled);
      status.div_last    = (div_cnt_ff == DCNT_BITS'(MEAN_BITS - 1));
      status.out_free    = out_free;
   end

   always_comb begin
      in_use_in = in_use_ff;
      if (cmd.write_miss && !full) begin
         in_use_in = in_use_ff + USE_W'(1);
      end
      scan_idx_in = scan_idx_ff;
      priority if (cmd.load_point) begin
         scan_idx_in = '0;
      end else if (cmd.scan_next) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESH_RESET;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            thr_ff <= csr_match_threshold;
         end
         in_use_ff <= in_use_in;
         if (cmd.write_hit || cmd.write_miss) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      if (cmd.load_point) begin
         point_ff <= MEAN_BITS'(req_point_value) << FRAC_BITS;
      end
      if (cmd.capture) begin
         prod_ff <= PROD_BITS'(mean_rd) * PROD_BITS'(cnt_rd);
         cnt_ff  <= cnt_rd;
      end
      if (cmd.div_init) begin
         rem_ff     <= sum[SUM_BITS-1 -: REM_BITS];
         quo_ff     <= sum[MEAN_BITS-1:0];
         divisor_ff <= DIVR_BITS'(cnt_ff) + DIVR_BITS'(1);
         newcnt_ff  <= (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + COUNT_BITS'(1);
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= qbit ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
         quo_ff     <= {quo_ff[MEAN_BITS-2:0], qbit};
         div_cnt_ff <= div_cnt_ff + DCNT_BITS'(1);
      end
      if (cmd.write_hit) begin
         out_idx_ff    <= scan_idx_ff;
         out_opened_ff <= 1'b0;
         out_drop_ff   <= 1'b0;
         out_mean_ff   <= quo_ff;
         out_size_ff   <= newcnt_ff;
      end else if (cmd.write_miss) begin
         if (full) begin
            out_idx_ff    <= '0;
            out_opened_ff <= 1'b0;
            out_drop_ff   <= 1'b1;
            out_mean_ff   <= '0;
            out_size_ff   <= '0;
         end else begin
            out_idx_ff    <= in_use_ff[IDX_W-1:0];
            out_opened_ff <= 1'b1;
            out_drop_ff   <= 1'b0;
            out_mean_ff   <= point_ff;
            out_size_ff   <= COUNT_BITS'(1);
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cluster_index   = out_idx_ff;
   assign rsp_opened_new      = out_opened_ff;
   assign rsp_table_full_drop = out_drop_ff;
   assign rsp_cluster_mean    = out_mean_ff;
   assign rsp_cluster_size    = out_size_ff;

   `LCRM_ASSERT_SAME(a_no_result_overwrite, clock, reset,
      cmd.write_hit || cmd.write_miss, !rsp_valid_ff || !rsp_stall)
   `LCRM_ASSERT_SAME(a_in_use_bounded, clock, reset,
      1'b1, in_use_ff <= USE_W'(MAX_CLUSTERS))
   `LCRM_ASSERT_NEXT(a_open_grows_table, clock, reset,
      cmd.write_miss && !full, in_use_ff == $past(in_use_ff) + USE_W'(1))

endmodule

`default_nettype wire
